// File: design/lkvc_pkg.sv
package lkvc_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic              operation;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } lkvc_item_t;

    typedef struct packed {
        logic              hit;
        logic signed [31:0] read_value;
    } lkvc_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_RESPOND
    } lkvc_state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic update;
    } lkvc_cmd_t;

endpackage

// File: design/lkvc_ram.sv
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output lkvc_pkg::lkvc_cmd_t cmd
);

    import lkvc_pkg::*;

    lkvc_state_t state_reg;
    lkvc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:  state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_RESPOND;
            ST_RESPOND:
            begin
                state_next = start ? ST_LOOKUP : ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        done       = 1'b0;
        cmd.lookup = 1'b0;
        cmd.update = 1'b0;
        case (state_reg)
            ST_IDLE:    ;
            ST_LOOKUP:
            begin
                busy       = 1'b1;
                cmd.lookup = 1'b1;
            end
            ST_UPDATE:
            begin
                busy       = 1'b1;
                cmd.update = 1'b1;
            end
            ST_RESPOND: done = 1'b1;
            default:    ;
        endcase
        cmd.accept = start && !busy;
    end

    // transaction walks lookup, update and respond in order
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.lookup)
        else $error("accepted transaction did not enter lookup");

    a_lookup_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> cmd.update)
        else $error("lookup not followed by update");

    a_update_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> done && !busy)
        else $error("update not followed by result strobe");

endmodule

// File: design/lkvc_datapath.sv
module lkvc_datapath #(
    parameter int CAPACITY = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lkvc_pkg::lkvc_cmd_t  cmd,
    input  lkvc_pkg::lkvc_item_t item,
    output lkvc_pkg::lkvc_result_t result
);

    import lkvc_pkg::*;

    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                op_reg;
    logic signed [31:0]  key_reg;
    logic signed [31:0]  val_reg;

    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] valid_next;
    logic [31:0]         key_mem_reg [CAPACITY];
    logic [RW-1:0]       rank_reg  [CAPACITY];
    logic [RW-1:0]       rank_next [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                hit_reg;
    logic                hit_next;
    logic [CAPACITY-1:0] sel_reg;
    logic [CAPACITY-1:0] sel_next;

    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] lru_vec;
    logic [CAPACITY-1:0] free_vec;
    logic [CAPACITY-1:0] match_first;
    logic [CAPACITY-1:0] free_first;
    logic [CAPACITY-1:0] lru_first;
    logic                full;
    logic                found;

    logic [RW-1:0]       slot_idx;
    logic [RW-1:0]       tgt_rank;
    logic [RW:0]         age_limit;
    logic                touch;
    logic                do_write;
    logic [31:0]         ram_rdata;

    assign full = (count_reg == CW'(CAPACITY));

    // parallel key compare and victim selection
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_mem_reg[i] == key_reg);
            lru_vec[i]   = valid_reg[i] && (rank_reg[i] == RW'(CAPACITY - 1));
        end
        free_vec    = ~valid_reg;
        match_first = match_vec & (~match_vec + CAPACITY'(1));
        free_first  = free_vec & (~free_vec + CAPACITY'(1));
        lru_first   = lru_vec & (~lru_vec + CAPACITY'(1));
        found       = |match_vec;
    end

    always_comb
    begin
        hit_next = hit_reg;
        sel_next = sel_reg;
        if (cmd.lookup)
        begin
            hit_next = found;
            if (found)
            begin
                sel_next = match_first;
            end
            else if (full)
            begin
                sel_next = lru_first;
            end
            else
            begin
                sel_next = free_first;
            end
        end
    end

    // slot index and rank of the selected entry
    always_comb
    begin
        slot_idx = '0;
        tgt_rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_reg[i])
            begin
                slot_idx = slot_idx | RW'(i);
                tgt_rank = tgt_rank | rank_reg[i];
            end
        end
    end

    assign do_write  = (op_reg == OP_WRITE);
    assign touch     = hit_reg || do_write;
    assign age_limit = (hit_reg || full) ? {1'b0, tgt_rank} : (RW + 1)'(CAPACITY);

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.update && touch)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (sel_reg[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && ({1'b0, rank_reg[i]} < age_limit))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            if (do_write)
            begin
                valid_next = valid_reg | sel_reg;
                if (!hit_reg && !full)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
            sel_reg   <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
            sel_reg   <= sel_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= item.operation;
            key_reg <= item.lookup_key;
            val_reg <= item.write_value;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cmd.update && do_write && sel_reg[i])
            begin
                key_mem_reg[i] <= key_reg;
            end
        end
    end

    lkvc_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.update && do_write),
        .addr  (slot_idx),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        result.hit = hit_reg;
        if (do_write)
        begin
            result.read_value = val_reg;
        end
        else if (hit_reg)
        begin
            result.read_value = ram_rdata;
        end
        else
        begin
            result.read_value = INT_MAX;
        end
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("occupancy count out of step with valid entries");

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $onehot(sel_reg))
        else $error("update without exactly one selected entry");

    a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> $onehot0(match_vec))
        else $error("key held by more than one valid entry");

endmodule

// File: design/lru_key_value_cache_core.sv
// fully associative key-value cache with least-recently-used replacement
// input channel: item is taken at a clock edge where start is high and busy
// is low; operation selects read lookup or write insert/update
// result channel: done pulses for one cycle with result.hit and
// result.read_value; the receiver cannot stall and must take it then
// latency: done is high in the third cycle after the accepting edge and the
// result is taken at the third edge after it
// throughput: one transaction every 3 cycles; start may be held high during
// the done cycle so the next transaction is taken at that edge
// the 3 cycles are lookup (parallel key compare and victim pick), update
// (rank aging, key and value write) and respond (registered value ram read)
// reset: all entries invalid, occupancy zero, controller idle; no clearing
// pass is needed, the cache accepts a transaction right after reset
module lru_key_value_cache_core #(
    parameter int CAPACITY = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lkvc_pkg::lkvc_item_t   item,
    output logic                   done,
    output lkvc_pkg::lkvc_result_t result
);

    import lkvc_pkg::*;

    lkvc_cmd_t cmd;

    lkvc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    lkvc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule
